@@ src/rwc_pkg.sv @@
// Shared types and constants for the read-ahead window controller.
package rwc_pkg;

    localparam int OFF_W    = 64;
    localparam int LEN_W    = 21;
    localparam int IDX_W    = 20;
    localparam int RLEN_W   = 25;  // holds a request length up to the largest window
    localparam int AGE_W    = 16;
    localparam int WCNT_W   = 5;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        K_READ    = 3'd0,
        K_BODY    = 3'd1,
        K_DONE    = 3'd2,
        K_TICK    = 3'd3,
        K_ABANDON = 3'd4,
        K_CLOSE   = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        ST_HIT      = 4'd0,
        ST_EOF      = 4'd1,
        ST_PARKED   = 4'd2,
        ST_INVALID  = 4'd3,
        ST_BUSY     = 4'd4,
        ST_BODY_OK  = 4'd5,
        ST_BODY_BAD = 4'd6,
        ST_IGNORED  = 4'd7,
        ST_DONE_OK  = 4'd8,
        ST_DONE_BAD = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        WK_NONE  = 3'd0,
        WK_LOOK  = 3'd1,
        WK_IO    = 3'd2,
        WK_AGAIN = 3'd3,
        WK_BADF  = 3'd4
    } t_wake;

    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READAHEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    // Classified request passed from front to back.
    typedef struct packed {
        logic [2:0]        kind;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic              ok;
        logic              eof;    // offset at or past file end
        logic [LEN_W-1:0]  lenc;   // length cut to bytes left
        logic [RLEN_W-1:0] rlen;   // length of a request this read would issue
        logic [OFF_W-1:0]  rend;   // offset + rlen
    } t_item;

endpackage

@@ src/rwc_front.sv @@
// Front stage: registers an incoming request and precomputes its file-range figures.
module rwc_front #(
    parameter int WINDOW_BYTES = 1048576
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_kind,
    input  logic [rwc_pkg::OFF_W-1:0]   i_offset,
    input  logic [rwc_pkg::LEN_W-1:0]   i_length,
    input  logic                        i_ok,
    input  logic [rwc_pkg::OFF_W-1:0]   i_file_size,
    input  logic [rwc_pkg::LEN_W-1:0]   i_readahead,
    output logic                        o_push,
    input  logic                        i_full,
    output rwc_pkg::t_item              o_item
);
    import rwc_pkg::*;

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [OFF_W-1:0]  left;
    logic [LEN_W:0]    want;
    logic [OFF_W-1:0]  m1;
    logic [RLEN_W-1:0] rlen;
    logic              load;

    always_comb begin
        left = i_file_size - i_offset;
        n_item.kind   = i_kind;
        n_item.offset = i_offset;
        n_item.length = i_length;
        n_item.ok     = i_ok;
        n_item.eof    = (i_offset >= i_file_size);
        n_item.lenc   = (OFF_W'(i_length) > left) ? left[LEN_W-1:0] : i_length;
        want = {1'b0, n_item.lenc} + {1'b0, i_readahead};
        m1   = (left < OFF_W'(want)) ? left : OFF_W'(want);
        rlen = (m1 > OFF_W'(WINDOW_BYTES)) ? RLEN_W'(WINDOW_BYTES) : m1[RLEN_W-1:0];
        n_item.rlen = rlen;
        n_item.rend = i_offset + OFF_W'(rlen);
    end

    assign load    = i_valid && !o_stall;
    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end
endmodule

@@ src/rwc_fifo.sv @@
// Two-entry queue between the front and back stages.
module rwc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rwc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rwc_pkg::t_item o_item
);
    import rwc_pkg::*;

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

@@ src/rwc_back.sv @@
// Back stage: window and request state, per-request decision and result register.
module rwc_back #(
    parameter int MAX_WAITERS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_pop,
    input  rwc_pkg::t_item              i_item,
    input  logic [rwc_pkg::AGE_W-1:0]   i_timeout,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [3:0]                  o_status,
    output logic [rwc_pkg::LEN_W-1:0]   o_count,
    output logic [rwc_pkg::IDX_W-1:0]   o_window_index,
    output logic                        o_request_valid,
    output logic [rwc_pkg::OFF_W-1:0]   o_request_start,
    output logic [rwc_pkg::LEN_W-1:0]   o_request_length,
    output logic [2:0]                  o_wake_code,
    output logic [rwc_pkg::WCNT_W-1:0]  o_wake_count,
    output logic                        o_expired
);
    import rwc_pkg::*;

    localparam int WC_W = $clog2(MAX_WAITERS + 1);
    localparam logic [WC_W-1:0] WC_MAX = WC_W'(MAX_WAITERS);

    logic [OFF_W-1:0]  r_win_lo, n_win_lo, r_win_hi, n_win_hi;
    logic [OFF_W-1:0]  r_fetch_lo, n_fetch_lo, r_fetch_hi, n_fetch_hi;
    logic [RLEN_W-1:0] r_span, n_span, r_recv, n_recv;
    logic              r_pending, n_pending;
    logic [AGE_W-1:0]  r_age, n_age;
    logic [WC_W-1:0]   r_wc, n_wc, wc_eff;

    logic              r_ov;
    t_status           n_status;
    logic [LEN_W-1:0]  n_count;
    logic [IDX_W-1:0]  n_idx;
    logic              n_req;
    logic [OFF_W-1:0]  n_req_start;
    logic [LEN_W-1:0]  n_req_len;
    t_wake             n_wake;
    logic [WCNT_W-1:0] n_wcount;
    logic              n_exp;

    logic [OFF_W-1:0]  avail, rel;
    logic [RLEN_W-1:0] room;
    logic              hit, covered;
    t_kind             kind;

    assign o_pop = i_valid && (!r_ov || !i_stall);
    assign kind  = t_kind'(i_item.kind);

    always_comb begin
        n_win_lo     = r_win_lo;
        n_win_hi     = r_win_hi;
        n_fetch_lo   = r_fetch_lo;
        n_fetch_hi   = r_fetch_hi;
        n_span       = r_span;
        n_recv       = r_recv;
        n_pending    = r_pending;
        n_age        = r_age;
        n_wc         = r_wc;
        wc_eff       = r_wc;
        n_status     = ST_IGNORED;
        n_count      = '0;
        n_idx        = '0;
        n_req        = 1'b0;
        n_req_start  = '0;
        n_req_len    = '0;
        n_wake       = WK_NONE;
        n_wcount     = '0;
        n_exp        = 1'b0;
        hit     = (i_item.offset >= r_win_lo) && (i_item.offset < r_win_hi);
        covered = r_pending && (i_item.offset >= r_fetch_lo)
                  && (i_item.offset < r_fetch_hi);
        avail   = r_win_hi - i_item.offset;
        rel     = i_item.offset - r_win_lo;
        room    = r_span - r_recv;
        case (kind)
            K_READ: begin
                if (i_item.eof) begin
                    n_status = ST_EOF;
                end else if (hit) begin
                    n_status = ST_HIT;
                    n_count  = (OFF_W'(i_item.lenc) > avail) ? avail[LEN_W-1:0]
                                                             : i_item.lenc;
                    n_idx    = rel[IDX_W-1:0];
                end else if (covered) begin
                    if (r_wc >= WC_MAX) begin
                        n_status = ST_BUSY;
                    end else begin
                        n_wc     = r_wc + WC_W'(1);
                        n_status = ST_PARKED;
                    end
                end else begin
                    if (r_pending) begin
                        // abort the outstanding request
                        n_pending    = 1'b0;
                        n_fetch_lo   = '0;
                        n_fetch_hi   = '0;
                        n_span       = '0;
                        n_recv       = '0;
                        n_age        = '0;
                        n_wake       = WK_AGAIN;
                        n_wcount     = WCNT_W'(r_wc);
                        wc_eff       = '0;
                    end
                    n_wc = wc_eff;
                    if (i_item.rlen == '0) begin
                        n_status = ST_INVALID;
                    end else if (wc_eff >= WC_MAX) begin
                        n_status = ST_BUSY;
                    end else begin
                        n_pending    = 1'b1;
                        n_fetch_lo   = i_item.offset;
                        n_fetch_hi   = i_item.rend;
                        n_span       = i_item.rlen;
                        n_recv       = '0;
                        n_age        = '0;
                        n_win_lo     = '0;
                        n_win_hi     = '0;
                        n_wc         = wc_eff + WC_W'(1);
                        n_req        = 1'b1;
                        n_req_start  = i_item.offset;
                        n_req_len    = i_item.rlen[LEN_W-1:0];
                        n_status     = ST_PARKED;
                    end
                end
            end
            K_BODY: begin
                if (!r_pending || (i_item.offset != r_fetch_lo + OFF_W'(r_recv))
                    || (r_recv > r_span) || (RLEN_W'(i_item.length) > room)) begin
                    n_status = ST_BODY_BAD;
                end else begin
                    n_status = ST_BODY_OK;
                    n_idx    = r_recv[IDX_W-1:0];
                    n_recv   = r_recv + RLEN_W'(i_item.length);
                end
            end
            K_DONE: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    n_age     = '0;
                    n_wcount  = WCNT_W'(r_wc);
                    n_wc      = '0;
                    if (!i_item.ok || (r_recv != r_span)) begin
                        n_win_lo     = '0;
                        n_win_hi     = '0;
                        n_wake       = WK_IO;
                        n_status     = ST_DONE_BAD;
                    end else begin
                        n_win_lo     = r_fetch_lo;
                        n_win_hi     = r_fetch_hi;
                        n_wake       = WK_LOOK;
                        n_status     = ST_DONE_OK;
                    end
                end
            end
            K_TICK: begin
                if (r_pending) begin
                    if (r_age != '1) n_age = r_age + AGE_W'(1);
                    n_exp = (n_age >= i_timeout);
                end
            end
            K_ABANDON: begin
                if (r_wc != '0) n_wc = r_wc - WC_W'(1);
            end
            K_CLOSE: begin
                n_pending    = 1'b0;
                n_fetch_lo   = '0;
                n_fetch_hi   = '0;
                n_span       = '0;
                n_recv       = '0;
                n_age        = '0;
                n_wake       = WK_BADF;
                n_wcount     = WCNT_W'(r_wc);
                n_wc         = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lo     <= '0;
            r_win_hi     <= '0;
            r_fetch_lo   <= '0;
            r_fetch_hi   <= '0;
            r_span       <= '0;
            r_recv       <= '0;
            r_pending    <= 1'b0;
            r_age        <= '0;
            r_wc         <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (o_pop) begin
                r_win_lo     <= n_win_lo;
                r_win_hi     <= n_win_hi;
                r_fetch_lo   <= n_fetch_lo;
                r_fetch_hi   <= n_fetch_hi;
                r_span       <= n_span;
                r_recv       <= n_recv;
                r_pending    <= n_pending;
                r_age        <= n_age;
                r_wc         <= n_wc;
                r_ov         <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_status         <= n_status;
            o_count          <= n_count;
            o_window_index   <= n_idx;
            o_request_valid  <= n_req;
            o_request_start  <= n_req_start;
            o_request_length <= n_req_len;
            o_wake_code      <= n_wake;
            o_wake_count     <= n_wcount;
            o_expired        <= n_exp;
        end
    end

    assign o_valid = r_ov;
endmodule

@@ src/readahead_window_controller.sv @@
// Top level of the read-ahead window controller: config registers and the front/queue/back chain.
// Path from request accept to result valid when nothing stalls: the front register, the queue
//   entry, then the back decision into the result register.
// Throughput: one request per cycle while the output does not stall; back decisions are combinational.
// A two-entry queue between front and back absorbs short output stalls.
// Reset (synchronous, active low) empties all stages, zeroes window/request/age/waiters.
module readahead_window_controller #(
    parameter int WINDOW_BYTES = 1048576,
    parameter int MAX_WAITERS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rwc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rwc_pkg::OFF_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_kind,
    input  logic [rwc_pkg::OFF_W-1:0]       i_offset,
    input  logic [rwc_pkg::LEN_W-1:0]       i_length,
    input  logic                            i_ok,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [3:0]                      o_status,
    output logic [rwc_pkg::LEN_W-1:0]       o_count,
    output logic [rwc_pkg::IDX_W-1:0]       o_window_index,
    output logic                            o_request_valid,
    output logic [rwc_pkg::OFF_W-1:0]       o_request_start,
    output logic [rwc_pkg::LEN_W-1:0]       o_request_length,
    output logic [2:0]                      o_wake_code,
    output logic [rwc_pkg::WCNT_W-1:0]      o_wake_count,
    output logic                            o_expired
);
    import rwc_pkg::*;

    logic [OFF_W-1:0] r_file_size;
    logic [LEN_W-1:0] r_readahead;
    logic [AGE_W-1:0] r_timeout;

    logic  push, full, q_valid, pop;
    t_item f_item, q_item;

    // Config writes; the user must write only while the block is idle, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= OFF_W'(1);
            r_readahead <= LEN_W'(262144);
            r_timeout   <= AGE_W'(30);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILE_SIZE: r_file_size <= i_cfg_data;
                CFG_READAHEAD: r_readahead <= i_cfg_data[LEN_W-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[AGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: latch request, work out eof, clamped length and candidate request range.
    rwc_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_kind      (i_kind),
        .i_offset    (i_offset),
        .i_length    (i_length),
        .i_ok        (i_ok),
        .i_file_size (r_file_size),
        .i_readahead (r_readahead),
        .o_push      (push),
        .i_full      (full),
        .o_item      (f_item)
    );

    rwc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: owns window/request state, applies one request per cycle unless the output stalls.
    rwc_back #(.MAX_WAITERS(MAX_WAITERS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .o_pop            (pop),
        .i_item           (q_item),
        .i_timeout        (r_timeout),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_status         (o_status),
        .o_count          (o_count),
        .o_window_index   (o_window_index),
        .o_request_valid  (o_request_valid),
        .o_request_start  (o_request_start),
        .o_request_length (o_request_length),
        .o_wake_code      (o_wake_code),
        .o_wake_count     (o_wake_count),
        .o_expired        (o_expired)
    );

    // A new request is only ever issued by a read that parks.
    a_req_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_request_valid |-> o_status == ST_PARKED)
        else $error("request issued without parked status");

    // Released waiters always carry a wake code.
    a_wake_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wake_count != '0 |-> o_wake_code != WK_NONE)
        else $error("waiters released with no wake code");

    // Bytes are served only on a hit.
    a_count_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_count != '0 |-> o_status == ST_HIT)
        else $error("count given on a non-hit");

    // Expiry is only flagged by ticks, which report ignored.
    a_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_expired |-> o_status == ST_IGNORED)
        else $error("expired flag on wrong status");
endmodule
